FILE: hdl/m3i_pkg.sv
// Shared types and constants for the 3x3 adjugate inverse pipeline.
// No dependencies.
`default_nettype none

package m3i_pkg;

    localparam int LANES     = 9;   // one lane per inverse element
    localparam int DET_W     = 50;  // Q24.24 determinant, wraps here
    localparam int ADJ_W     = 40;  // adjugate element, wraps here
    localparam int QUO_W     = 32;  // quotient bits produced by the divider
    localparam int INV_SHIFT = 24;
    localparam int REM_W     = DET_W;

    // state of the nine long divisions as they travel down the pipe
    typedef struct packed {
        logic [LANES-1:0][REM_W-1:0] rem;   // partial remainder
        logic [LANES-1:0][QUO_W-1:0] nbits; // dividend bits still to shift in
        logic [LANES-1:0][QUO_W-1:0] quo;   // quotient bits so far
        logic [LANES-1:0]            big;   // quotient reaches 2^32 or more
        logic [LANES-1:0]            aneg;  // adjugate element negative
        logic [DET_W-1:0]            dmag;  // divisor magnitude
        logic                        dneg;
        logic [DET_W-1:0]            det;
    } t_div;

endpackage

`default_nettype wire

FILE: hdl/m3i_if.sv
// Handshake interfaces for the matrix input and the inverse result channels.
// Depends on m3i_pkg for the fixed result widths.
`default_nettype none

interface m3i_in_if #(
    parameter int W = 16
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;

    modport source (output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                    input ready);
    modport sink   (input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                    output ready);
endinterface

interface m3i_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [m3i_pkg::QUO_W-1:0]     inv00, inv01, inv02;
    logic signed [m3i_pkg::QUO_W-1:0]     inv10, inv11, inv12;
    logic signed [m3i_pkg::QUO_W-1:0]     inv20, inv21, inv22;
    logic signed [m3i_pkg::DET_W-1:0]     determinant;
    logic                                 singular;

    modport source (output valid, inv00, inv01, inv02, inv10, inv11, inv12,
                    inv20, inv21, inv22, determinant, singular, input ready);
    modport sink   (input valid, inv00, inv01, inv02, inv10, inv11, inv12,
                    inv20, inv21, inv22, determinant, singular, output ready);
endinterface

`default_nettype wire

FILE: hdl/m3i_front.sv
// Front end: minors, cofactors, determinant, magnitudes and divider set-up.
// Five register stages, all advancing on i_adv. Depends on m3i_pkg.
`default_nettype none

module m3i_front #(
    parameter int W = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_adv,
    input  wire logic signed [W-1:0]  i_e [3][3],
    output m3i_pkg::t_div             o_div
);
    localparam int DW = m3i_pkg::DET_W;
    localparam int AW = m3i_pkg::ADJ_W;
    localparam int QW = m3i_pkg::QUO_W;
    // adjugate bits that land below 2^32 once N = |adj| * 2^24 is formed
    localparam int LOW_BITS = QW - m3i_pkg::INV_SHIFT;

    // stage 1: minor products
    logic signed [2*W-1:0] r_pa [3][3];
    logic signed [2*W-1:0] r_pb [3][3];
    logic signed [W-1:0]   r_row0_1 [3];
    // stage 2: cofactors
    logic signed [2*W:0]   r_cof [3][3];
    logic signed [W-1:0]   r_row0_2 [3];
    // stage 3: determinant terms, adjugate wrapped to 40 bits
    logic signed [DW-1:0]  r_dp [3];
    logic signed [AW-1:0]  r_adj [m3i_pkg::LANES];
    // stage 4: magnitudes
    logic [DW-1:0]         r_det;
    logic [DW-1:0]         r_dmag;
    logic                  r_dneg;
    logic [AW-1:0]         r_amag [m3i_pkg::LANES];
    logic [m3i_pkg::LANES-1:0] r_aneg;
    // stage 5
    m3i_pkg::t_div         r_div;

    logic [DW-1:0] n_det;
    logic [DW-1:0] w_top [m3i_pkg::LANES];   // N >> 32, the dividend above bit 32

    for (genvar r = 0; r < 3; r++) begin : g_row
        for (genvar c = 0; c < 3; c++) begin : g_col
            localparam int R1 = (r + 1) % 3;
            localparam int R2 = (r + 2) % 3;
            localparam int C1 = (c + 1) % 3;
            localparam int C2 = (c + 2) % 3;
            localparam int LN = c * 3 + r;   // transpose into the adjugate

            always_ff @(posedge i_clk) begin
                if (i_adv) begin
                    r_pa[r][c] <= i_e[R1][C1] * i_e[R2][C2];
                    r_pb[r][c] <= i_e[R1][C2] * i_e[R2][C1];
                    r_cof[r][c] <= (2*W+1)'(r_pa[r][c]) - (2*W+1)'(r_pb[r][c]);
                    r_adj[LN] <= AW'(r_cof[r][c]);
                end
            end
        end
    end

    for (genvar j = 0; j < 3; j++) begin : g_dp
        logic signed [DW-1:0] w_a;
        logic signed [DW-1:0] w_c;
        assign w_a = DW'(r_row0_2[j]);
        assign w_c = DW'(r_cof[0][j]);
        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_row0_1[j] <= i_e[0][j];
                r_row0_2[j] <= r_row0_1[j];
                r_dp[j]     <= w_a * w_c;
            end
        end
    end

    assign n_det = DW'(r_dp[0] + r_dp[1] + r_dp[2]);

    always_comb begin
        for (int k = 0; k < m3i_pkg::LANES; k++) begin
            w_top[k] = DW'(r_amag[k][AW-1:LOW_BITS]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_det  <= n_det;
            r_dneg <= n_det[DW-1];
            r_dmag <= n_det[DW-1] ? (~n_det + 1'b1) : n_det;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int k = 0; k < m3i_pkg::LANES; k++) begin
                r_aneg[k] <= r_adj[k][AW-1];
                r_amag[k] <= r_adj[k][AW-1] ? (~r_adj[k] + 1'b1) : r_adj[k];
                r_div.rem[k]   <= w_top[k];
                r_div.nbits[k] <= {r_amag[k][LOW_BITS-1:0],
                                   (QW-LOW_BITS)'(0)};
                r_div.quo[k]   <= '0;
                r_div.big[k]   <= (w_top[k] >= r_dmag);
                r_div.aneg[k]  <= r_aneg[k];
            end
            r_div.dmag <= r_dmag;
            r_div.dneg <= r_dneg;
            r_div.det  <= r_det;
        end
    end

    assign o_div = r_div;

endmodule

`default_nettype wire

FILE: hdl/m3i_div_step.sv
// One restoring division step for all nine lanes, registered.
// Depends on m3i_pkg.
`default_nettype none

module m3i_div_step (
    input  wire logic  i_clk,
    input  wire logic  i_adv,
    input  m3i_pkg::t_div i_div,
    output m3i_pkg::t_div o_div
);
    localparam int RW = m3i_pkg::REM_W;
    localparam int QW = m3i_pkg::QUO_W;

    m3i_pkg::t_div r_div;
    m3i_pkg::t_div n_div;

    always_comb begin
        logic [RW:0] sh;
        logic        ge;
        n_div = i_div;
        for (int k = 0; k < m3i_pkg::LANES; k++) begin
            sh = {i_div.rem[k], i_div.nbits[k][QW-1]};
            ge = (sh >= {1'b0, i_div.dmag});
            n_div.rem[k]   = ge ? RW'(sh - {1'b0, i_div.dmag}) : RW'(sh);
            n_div.nbits[k] = {i_div.nbits[k][QW-2:0], 1'b0};
            n_div.quo[k]   = {i_div.quo[k][QW-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_div <= n_div;
        end
    end

    assign o_div = r_div;

endmodule

`default_nettype wire

FILE: hdl/mat3_inverse_adjugate_top.sv
// Top level of the 3x3 adjugate inverse pipeline.
// Depends on m3i_pkg, m3i_if, m3i_front and m3i_div_step.
//
// Usage
//   i_mat transfers one matrix of nine signed Q8.8 elements (ELEM_WIDTH bits
//   each); o_inv transfers the nine Q16.16 inverse elements, the Q24.24
//   determinant and the singular flag. Both are valid/ready channels.
//   Throughput: one matrix per cycle, back to back, no gaps, as long as o_inv takes each result.
//   Pipeline: 38 register stages between i_mat and o_inv - five front
//   stages (products, cofactors, determinant terms, sum and magnitudes,
//   divider set-up), 32 restoring division steps (one quotient bit per
//   stage for all nine lanes at once) and the output register.
//   A singular matrix gives zero inverse elements and singular = 1.
//   Stall: while o_inv holds a result that is not taken, the whole pipe
//   freezes and i_mat.ready drops; nothing is lost or repeated. Bubbles
//   advance freely whenever the output register is empty or being taken.
//   Reset clears only the valid bits; the datapath needs no clearing.
`default_nettype none

module mat3_inverse_adjugate_top #(
    parameter int ELEM_WIDTH = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    m3i_in_if.sink     i_mat,
    m3i_out_if.source  o_inv
);
    localparam int QW    = m3i_pkg::QUO_W;
    localparam int DW    = m3i_pkg::DET_W;
    localparam int NSTEP = QW;
    localparam int FRONT = 5;
    localparam int NVLD  = FRONT + NSTEP;   // valid bits ahead of the output

    logic                    w_adv;
    logic signed [ELEM_WIDTH-1:0] w_e [3][3];
    m3i_pkg::t_div           w_div [NSTEP+1];

    logic [NVLD-1:0]         r_vld;
    logic                    r_out_vld;
    logic [QW-1:0]           r_inv [m3i_pkg::LANES];
    logic [DW-1:0]           r_det;
    logic                    r_sing;
    logic [QW-1:0]           n_inv [m3i_pkg::LANES];

    // the whole pipe moves unless a finished result is stuck at the output
    assign w_adv       = !r_out_vld || o_inv.ready;
    assign i_mat.ready = w_adv;

    assign w_e[0][0] = i_mat.a00;
    assign w_e[0][1] = i_mat.a01;
    assign w_e[0][2] = i_mat.a02;
    assign w_e[1][0] = i_mat.a10;
    assign w_e[1][1] = i_mat.a11;
    assign w_e[1][2] = i_mat.a12;
    assign w_e[2][0] = i_mat.a20;
    assign w_e[2][1] = i_mat.a21;
    assign w_e[2][2] = i_mat.a22;

    m3i_front #(
        .W (ELEM_WIDTH)
    ) u_front (
        .i_clk (i_clk),
        .i_adv (w_adv),
        .i_e   (w_e),
        .o_div (w_div[0])
    );

    for (genvar s = 0; s < NSTEP; s++) begin : g_step
        m3i_div_step u_step (
            .i_clk (i_clk),
            .i_adv (w_adv),
            .i_div (w_div[s]),
            .o_div (w_div[s+1])
        );
    end

    // sign, saturation and the singular case
    always_comb begin
        logic neg;
        logic [QW-1:0] q;
        for (int k = 0; k < m3i_pkg::LANES; k++) begin
            neg = w_div[NSTEP].aneg[k] ^ w_div[NSTEP].dneg;
            q   = w_div[NSTEP].quo[k];
            if (w_div[NSTEP].det == '0) begin
                n_inv[k] = '0;
            end else if (neg) begin
                if (w_div[NSTEP].big[k] || q > {1'b1, (QW-1)'(0)}) begin
                    n_inv[k] = {1'b1, (QW-1)'(0)};
                end else begin
                    n_inv[k] = ~q + 1'b1;
                end
            end else begin
                if (w_div[NSTEP].big[k] || q[QW-1]) begin
                    n_inv[k] = {1'b0, {(QW-1){1'b1}}};
                end else begin
                    n_inv[k] = q;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_vld     <= {r_vld[NVLD-2:0], i_mat.valid};
            r_out_vld <= r_vld[NVLD-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_inv  <= n_inv;
            r_det  <= w_div[NSTEP].det;
            r_sing <= (w_div[NSTEP].det == '0);
        end
    end

    assign o_inv.valid       = r_out_vld;
    assign o_inv.inv00       = r_inv[0];
    assign o_inv.inv01       = r_inv[1];
    assign o_inv.inv02       = r_inv[2];
    assign o_inv.inv10       = r_inv[3];
    assign o_inv.inv11       = r_inv[4];
    assign o_inv.inv12       = r_inv[5];
    assign o_inv.inv20       = r_inv[6];
    assign o_inv.inv21       = r_inv[7];
    assign o_inv.inv22       = r_inv[8];
    assign o_inv.determinant = r_det;
    assign o_inv.singular    = r_sing;

    // singular result carries a zero inverse (the diagonal elements are checked)
    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_inv.valid && o_inv.singular |->
            o_inv.inv00 == '0 && o_inv.inv11 == '0 && o_inv.inv22 == '0)
        else $error("singular result with nonzero inverse");

    // flag and determinant agree
    a_sing_det: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_inv.valid |-> (o_inv.singular == (o_inv.determinant == '0)))
        else $error("singular flag disagrees with determinant");

    // last pipe slot reaches the output whenever the pipe moves
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && r_vld[NVLD-1] |=> o_inv.valid)
        else $error("item lost between pipe and output register");

    // input side only stalls behind a held result
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_mat.ready |-> o_inv.valid && !o_inv.ready)
        else $error("input stalled without output back-pressure");

endmodule

`default_nettype wire
